FILE: sv/lpht_pkg.sv
// Shared constants and types for the linear probing hash table.
`default_nettype none
package lpht_pkg;
	localparam int DEF_SLOTS = 1024;
	localparam int KEY_W = 64;
	localparam int VAL_W = 64;
	localparam int CNT_OUT_W = 11;
	localparam logic [CNT_OUT_W-1:0] MAX_RESET = 11'd768;

	localparam logic [2:0] KIND_GET = 3'd0;
	localparam logic [2:0] KIND_SET = 3'd1;
	localparam logic [2:0] KIND_POP = 3'd2;
	localparam logic [2:0] KIND_SETDEF = 3'd3;
	localparam logic [2:0] KIND_CLEAR = 3'd4;
	localparam logic [2:0] KIND_POPITEM = 3'd5;

	localparam logic [1:0] ST_EMPTY = 2'd0;
	localparam logic [1:0] ST_USED = 2'd1;
	localparam logic [1:0] ST_TOMB = 2'd2;

	typedef struct packed {
		logic st;
		logic key;
		logic val;
	} wr_en_t;
endpackage
`default_nettype wire

FILE: sv/linear_probe_hash_table.sv
// Top level of the linear probing hash table with its request sequencer.
// Requests enter on s_tvalid/s_tready: s_tuser carries the kind, s_tdata the
// key and the value. One result per request leaves on m_tvalid/m_tready.
// cfg_we writes the occupancy limit max_entries from cfg_wdata. It is to be
// written only while idle; the block itself does not enforce this.
// A request probes one slot at a time, starting at key mod TABLE_SLOTS for
// get, set, pop and setdefault; popitem scans from slot 0, clear rewrites
// every slot and an unused kind is answered without a probe. The result is
// offered before the next request can be taken. With a slot count that is
// not a power of two, the start slot comes from a reciprocal-multiply
// reduction of 16 key bits at a time.
// The slot memory read port sets the probe rate.
// After reset a clearing pass marks every slot empty; no request is taken
// meanwhile. max_entries resets to 768.
// One request is in work at a time; a result held by a stalled receiver
// blocks the next request until it is taken.
`default_nettype none
module linear_probe_hash_table #(
	parameter int TABLE_SLOTS = lpht_pkg::DEF_SLOTS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [10:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,   // key[63:0], value[127:64]
	input  wire logic [2:0]   s_tuser,   // kind[2:0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// found[0], result_value[64:1], result_key[128:65], entry_count[139:129],
	// full_res[140], zero[143:141]
	output logic [143:0]      m_tdata
);
	localparam int IW = $clog2(TABLE_SLOTS);
	localparam int CW = ($clog2(TABLE_SLOTS + 1) > 11) ? $clog2(TABLE_SLOTS + 1) : 11;
	localparam bit POW2 = (TABLE_SLOTS == (1 << IW));
	localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);

	localparam logic [2:0] S_CLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RED = 3'd2;
	localparam logic [2:0] S_RD = 3'd3;
	localparam logic [2:0] S_EV = 3'd4;

	logic [2:0]          state_q;
	logic [CW-1:0]       cnt_q;
	logic [10:0]         max_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       steps_q;
	logic [IW-1:0]       hole_q;
	logic                has_hole_q;
	logic                clr_rsp_q;
	logic [2:0]          kind_q;
	logic signed [63:0]  key_q;
	logic signed [63:0]  val_q;
	logic                out_valid_q;
	logic [143:0]        out_q;

	logic                red_start;
	logic                red_done;
	logic [IW-1:0]       red_rem;
	lpht_pkg::wr_en_t    we;
	logic [IW-1:0]       waddr;
	logic [1:0]          wst;
	logic [1:0]          rd_st;
	logic [63:0]         rd_key;
	logic [63:0]         rd_val;

	logic                accept;
	logic                is_empty, is_tomb, is_hit, lap_end, term;
	logic                hole_ok;
	logic [IW-1:0]       hole_now;
	logic                is_pi, ins, refuse, pi_hit;
	logic [IW-1:0]       idx_inc;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE) && !out_valid_q;
	assign red_start = accept && !POW2 &&
		(s_tuser != lpht_pkg::KIND_CLEAR) && (s_tuser != lpht_pkg::KIND_POPITEM) &&
		(s_tuser <= lpht_pkg::KIND_POPITEM);

	lpht_reduce #(.SLOTS(TABLE_SLOTS)) u_reduce (
		.clk(clk), .arst_n(arst_n), .start(red_start), .key(s_tdata[63:0]),
		.done(red_done), .rem(red_rem)
	);

	lpht_store #(.SLOTS(TABLE_SLOTS)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wst(wst), .wkey(key_q), .wval(val_q),
		.re(state_q == S_RD), .raddr(idx_q), .rst(rd_st), .rkey(rd_key), .rval(rd_val)
	);

	assign idx_inc = (idx_q == LAST) ? '0 : idx_q + IW'(1);
	assign is_pi = (kind_q == lpht_pkg::KIND_POPITEM);
	assign is_empty = (rd_st == lpht_pkg::ST_EMPTY);
	assign is_tomb = (rd_st == lpht_pkg::ST_TOMB);
	assign is_hit = (rd_st == lpht_pkg::ST_USED) && (rd_key == key_q);
	assign lap_end = (steps_q == LAST);
	assign term = is_empty || is_hit || lap_end;
	assign hole_ok = has_hole_q || is_empty || is_tomb;
	assign hole_now = has_hole_q ? hole_q : idx_q;
	assign pi_hit = (rd_st == lpht_pkg::ST_USED);
	assign ins = !is_hit &&
		((kind_q == lpht_pkg::KIND_SET) || (kind_q == lpht_pkg::KIND_SETDEF));
	assign refuse = ins && ((cnt_q >= CW'(max_q)) || !hole_ok);

	always_comb begin
		we = '0;
		waddr = idx_q;
		wst = lpht_pkg::ST_TOMB;
		if (state_q == S_CLR) begin
			we.st = 1'b1;
			wst = lpht_pkg::ST_EMPTY;
		end else if (state_q == S_EV) begin
			if (is_pi) begin
				we.st = pi_hit;
			end else if (term) begin
				if (is_hit && kind_q == lpht_pkg::KIND_SET) we.val = 1'b1;
				if (is_hit && kind_q == lpht_pkg::KIND_POP) we.st = 1'b1;
				if (ins && !refuse) begin
					we = '{st: 1'b1, key: 1'b1, val: 1'b1};
					waddr = hole_now;
					wst = lpht_pkg::ST_USED;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			idx_q <= '0;
			cnt_q <= '0;
			max_q <= lpht_pkg::MAX_RESET;
			clr_rsp_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) max_q <= cfg_wdata;
			if (m_tvalid && m_tready) out_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					idx_q <= idx_inc;
					if (idx_q == LAST) begin
						state_q <= S_IDLE;
						cnt_q <= '0;
						if (clr_rsp_q) out_valid_q <= 1'b1;
						clr_rsp_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (s_tuser == lpht_pkg::KIND_CLEAR) begin
							state_q <= S_CLR;
							idx_q <= '0;
							clr_rsp_q <= 1'b1;
						end else if (s_tuser == lpht_pkg::KIND_POPITEM) begin
							state_q <= S_RD;
							idx_q <= '0;
						end else if (s_tuser > lpht_pkg::KIND_POPITEM) begin
							out_valid_q <= 1'b1;
						end else if (POW2) begin
							state_q <= S_RD;
							idx_q <= s_tdata[IW-1:0];
						end else begin
							state_q <= S_RED;
						end
					end
				end
				S_RED: begin
					if (red_done) begin
						idx_q <= red_rem;
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_EV;
				S_EV: begin
					if (is_pi) begin
						if (pi_hit || idx_q == LAST) begin
							state_q <= S_IDLE;
							out_valid_q <= 1'b1;
							if (pi_hit && cnt_q != '0) cnt_q <= cnt_q - CW'(1);
						end else begin
							idx_q <= idx_inc;
							state_q <= S_RD;
						end
					end else if (term) begin
						state_q <= S_IDLE;
						out_valid_q <= 1'b1;
						if (ins && !refuse) cnt_q <= cnt_q + CW'(1);
						if (is_hit && kind_q == lpht_pkg::KIND_POP) cnt_q <= cnt_q - CW'(1);
					end else begin
						idx_q <= idx_inc;
						state_q <= S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser;
			key_q <= s_tdata[63:0];
			val_q <= s_tdata[127:64];
			steps_q <= '0;
			has_hole_q <= 1'b0;
			hole_q <= '0;
			out_q <= {4'b0, cnt_q[10:0], 129'b0};
		end
		if (state_q == S_EV && !is_pi && !term) begin
			steps_q <= steps_q + IW'(1);
			if (!has_hole_q && is_tomb) begin
				has_hole_q <= 1'b1;
				hole_q <= idx_q;
			end
		end
		if (state_q == S_CLR && idx_q == LAST) out_q[139:129] <= '0;
		if (state_q == S_EV) begin
			if (is_pi) begin
				out_q[0] <= pi_hit;
				out_q[64:1] <= pi_hit ? rd_val : '0;
				out_q[128:65] <= pi_hit ? rd_key : '0;
				out_q[139:129] <= (pi_hit && cnt_q != '0) ? 11'(cnt_q - CW'(1))
					: cnt_q[10:0];
			end else if (term) begin
				out_q[0] <= is_hit;
				out_q[140] <= refuse;
				case (kind_q)
					lpht_pkg::KIND_GET, lpht_pkg::KIND_SETDEF:
						out_q[64:1] <= is_hit ? rd_val : val_q;
					lpht_pkg::KIND_POP: begin
						out_q[64:1] <= is_hit ? rd_val : '0;
						out_q[139:129] <= is_hit ? 11'(cnt_q - CW'(1)) : cnt_q[10:0];
					end
					default: out_q[64:1] <= '0;
				endcase
				if (ins && !refuse) out_q[139:129] <= 11'(cnt_q + CW'(1));
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;
endmodule
`default_nettype wire

FILE: sv/lpht_reduce.sv
// Reduction of a 64-bit key modulo the slot count by reciprocal multiplication.
`default_nettype none
module lpht_reduce #(
	parameter int SLOTS = lpht_pkg::DEF_SLOTS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [63:0]              key,
	output logic                          done,
	output logic [$clog2(SLOTS)-1:0]      rem
);
	localparam int IW = $clog2(SLOTS);
	localparam logic [31:0] MOD = 32'(SLOTS);
	localparam logic [31:0] RCP = 32'((64'd1 << 32) / 64'(SLOTS));

	localparam logic [1:0] P_MUL = 2'd0;
	localparam logic [1:0] P_SUB = 2'd1;
	localparam logic [1:0] P_FIX = 2'd2;

	logic          busy_q;
	logic          done_q;
	logic [1:0]    phase_q;
	logic [1:0]    dig_q;
	logic [63:0]   sh_q;
	logic [31:0]   r_q;
	logic [31:0]   q_q;
	logic [31:0]   part;
	logic [31:0]   mul_a;
	logic [31:0]   mul_b;
	logic [63:0]   prod;

	// partial remainder followed by the next 16 key bits
	assign part = {r_q[15:0], sh_q[63:48]};
	assign mul_a = (phase_q == P_MUL) ? part : q_q;
	assign mul_b = (phase_q == P_MUL) ? RCP : MOD;
	assign prod = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			phase_q <= P_MUL;
			dig_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				phase_q <= P_MUL;
				dig_q <= '0;
			end else if (busy_q) begin
				case (phase_q)
					P_MUL: phase_q <= P_SUB;
					P_SUB: phase_q <= P_FIX;
					default: begin
						phase_q <= P_MUL;
						dig_q <= dig_q + 2'd1;
						if (dig_q == 2'd3) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	// estimate falls short by at most one, so one conditional subtract corrects it
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= key;
			r_q <= '0;
		end else if (busy_q) begin
			case (phase_q)
				P_MUL: q_q <= prod[63:32];
				P_SUB: r_q <= part - prod[31:0];
				default: begin
					r_q <= (r_q >= MOD) ? r_q - MOD : r_q;
					sh_q <= {sh_q[47:0], 16'd0};
				end
			endcase
		end
	end

	assign done = done_q;
	assign rem = r_q[IW-1:0];
endmodule
`default_nettype wire

FILE: sv/lpht_store.sv
// Slot memories: status, key and value, one write and one registered read.
`default_nettype none
module lpht_store #(
	parameter int SLOTS = lpht_pkg::DEF_SLOTS
) (
	input  wire logic                        clk,
	input  wire lpht_pkg::wr_en_t            we,
	input  wire logic [$clog2(SLOTS)-1:0]    waddr,
	input  wire logic [1:0]                  wst,
	input  wire logic [63:0]                 wkey,
	input  wire logic [63:0]                 wval,
	input  wire logic                        re,
	input  wire logic [$clog2(SLOTS)-1:0]    raddr,
	output logic [1:0]                       rst,
	output logic [63:0]                      rkey,
	output logic [63:0]                      rval
);
	logic [1:0]  st_mem [SLOTS];
	logic [63:0] key_mem [SLOTS];
	logic [63:0] val_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we.st) st_mem[waddr] <= wst;
		if (we.key) key_mem[waddr] <= wkey;
		if (we.val) val_mem[waddr] <= wval;
		if (re) begin
			rst <= st_mem[raddr];
			rkey <= key_mem[raddr];
			rval <= val_mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for linear_probe_hash_table: directed table, random requests, predictor.
`timescale 1ns / 100ps
module testbench;
	localparam int SLOTS = lpht_pkg::DEF_SLOTS;
	localparam logic [2:0] KIND_RSV6 = 3'd6;
	localparam logic [2:0] KIND_RSV7 = 3'd7;
	localparam logic [63:0] KEY_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] KEY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int STALL_LIMIT = 20000;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic        found;
		logic [63:0] rval;
		logic [63:0] rkey;
		logic [10:0] cnt;
		logic        full;
	} answer_t;

	typedef struct {
		logic [2:0]  kind;
		logic [63:0] key;
		logic [63:0] val;
		bit          typed;
		answer_t     ans;
	} dir_row_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [10:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;   // key[63:0], value[127:64]
	logic [2:0]   s_tuser;   // kind[2:0]
	logic         m_tvalid;
	logic         m_tready;
	// found[0], result_value[64:1], result_key[128:65], entry_count[139:129],
	// full_res[140], zero[143:141]
	logic [143:0] m_tdata;

	logic [1:0]  slot_st[SLOTS];
	logic [63:0] slot_k[SLOTS];
	logic [63:0] slot_v[SLOTS];
	int unsigned used_cnt;
	int unsigned entry_limit;

	answer_t     answer_q[$];
	dir_row_t    dir_tab[20];
	logic [53:0] hi_pool[4];
	int          n_req, n_res, n_err, n_refused, idle_cycles;
	bit          quiet, long_go, long_done;

	linear_probe_hash_table u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit slot_lookup(input logic [63:0] k, output int hit,
			output int hole, output bit has_hole);
		int idx;
		idx = int'(k[9:0]);
		hit = 0;
		hole = 0;
		has_hole = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_st[idx] == lpht_pkg::ST_EMPTY) begin
				if (!has_hole) begin
					hole = idx;
					has_hole = 1'b1;
				end
				return 1'b0;
			end
			if (slot_st[idx] == lpht_pkg::ST_TOMB) begin
				if (!has_hole) begin
					hole = idx;
					has_hole = 1'b1;
				end
			end else if (slot_k[idx] == k) begin
				hit = idx;
				return 1'b1;
			end
			idx = (idx + 1) % SLOTS;
		end
		return 1'b0;
	endfunction

	function automatic logic place_key(input logic [63:0] k, input logic [63:0] v,
			input bit has_hole, input int hole);
		if (used_cnt >= entry_limit || !has_hole)
			return 1'b1;
		slot_st[hole] = lpht_pkg::ST_USED;
		slot_k[hole] = k;
		slot_v[hole] = v;
		used_cnt++;
		return 1'b0;
	endfunction

	function automatic answer_t table_apply(input logic [2:0] kd, input logic [63:0] k,
			input logic [63:0] v);
		answer_t r;
		int hit, hole;
		bit has_hole, present;
		r = '0;
		case (kd)
			lpht_pkg::KIND_GET: begin
				present = slot_lookup(k, hit, hole, has_hole);
				r.found = present;
				r.rval = present ? slot_v[hit] : v;
			end
			lpht_pkg::KIND_SET: begin
				present = slot_lookup(k, hit, hole, has_hole);
				r.found = present;
				if (present)
					slot_v[hit] = v;
				else
					r.full = place_key(k, v, has_hole, hole);
			end
			lpht_pkg::KIND_POP: begin
				present = slot_lookup(k, hit, hole, has_hole);
				r.found = present;
				if (present) begin
					r.rval = slot_v[hit];
					slot_st[hit] = lpht_pkg::ST_TOMB;
					used_cnt--;
				end
			end
			lpht_pkg::KIND_SETDEF: begin
				present = slot_lookup(k, hit, hole, has_hole);
				r.found = present;
				if (present) begin
					r.rval = slot_v[hit];
				end else begin
					r.rval = v;
					r.full = place_key(k, v, has_hole, hole);
				end
			end
			lpht_pkg::KIND_CLEAR: begin
				foreach (slot_st[i])
					slot_st[i] = lpht_pkg::ST_EMPTY;
				used_cnt = 0;
			end
			lpht_pkg::KIND_POPITEM: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_st[i] == lpht_pkg::ST_USED) begin
						r.found = 1'b1;
						r.rkey = slot_k[i];
						r.rval = slot_v[i];
						slot_st[i] = lpht_pkg::ST_TOMB;
						if (used_cnt > 0)
							used_cnt--;
						break;
					end
				end
			end
			default: ;
		endcase
		r.cnt = used_cnt[10:0];
		return r;
	endfunction

	task automatic send_request(input logic [2:0] kd, input logic [63:0] k,
			input logic [63:0] v, input bit typed, input answer_t typed_ans);
		answer_t p;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kd;
		s_tdata <= {v, k};
		do @(posedge clk); while (!s_tready);
		p = table_apply(kd, k, v);
		if (p.full)
			n_refused++;
		answer_q.push_back(typed ? typed_ans : p);
		n_req++;
	endtask

	task automatic write_limit(input logic [10:0] lim);
		s_tvalid <= 1'b0;
		while (answer_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		entry_limit = 32'(lim);
	endtask

	function automatic logic [63:0] pick_key();
		logic [9:0] idx;
		if ($urandom_range(0, 19) == 0)
			return {$urandom, $urandom};
		idx = ($urandom_range(0, 4) == 0) ? 10'(1008 + $urandom_range(0, 15))
			: 10'($urandom_range(0, 31));
		return {hi_pool[$urandom_range(0, 3)], idx};
	endfunction

	function automatic logic [2:0] pick_kind();
		int w;
		w = $urandom_range(0, 99);
		if (w < 30) return lpht_pkg::KIND_SET;
		if (w < 50) return lpht_pkg::KIND_GET;
		if (w < 65) return lpht_pkg::KIND_POP;
		if (w < 82) return lpht_pkg::KIND_SETDEF;
		if (w < 92) return lpht_pkg::KIND_POPITEM;
		if (w < 94) return lpht_pkg::KIND_CLEAR;
		if (w < 97) return KIND_RSV6;
		return KIND_RSV7;
	endfunction

	task automatic random_burst(input int n);
		for (int i = 0; i < n; i++)
			send_request(pick_kind(), pick_key(), {$urandom, $urandom}, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		answer_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.found = m_tdata[0];
			got.rval = m_tdata[64:1];
			got.rkey = m_tdata[128:65];
			got.cnt = m_tdata[139:129];
			got.full = m_tdata[140];
			n_res++;
			if (n_res == 150)
				long_go = 1'b1;
			if (answer_q.size() == 0) begin
				$error("result with nothing outstanding: %h", m_tdata);
				n_err++;
			end else begin
				want = answer_q.pop_front();
				if (got.found !== want.found) begin
					$error("found: expected %0h, got %0h", want.found, got.found);
					n_err++;
				end
				if (got.rval !== want.rval) begin
					$error("result_value: expected %h, got %h", want.rval, got.rval);
					n_err++;
				end
				if (got.rkey !== want.rkey) begin
					$error("result_key: expected %h, got %h", want.rkey, got.rkey);
					n_err++;
				end
				if (got.cnt !== want.cnt) begin
					$error("entry_count: expected %0d, got %0d", want.cnt, got.cnt);
					n_err++;
				end
				if (got.full !== want.full) begin
					$error("full_res: expected %0h, got %0h", want.full, got.full);
					n_err++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("timeout: no request or result for %0d cycles", STALL_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (long_go && !long_done) begin
				long_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		idle_cycles = 0;
		foreach (slot_st[i]) begin
			slot_st[i] = lpht_pkg::ST_EMPTY;
			slot_k[i] = '0;
			slot_v[i] = '0;
		end
		used_cnt = 0;
		entry_limit = 32'(lpht_pkg::MAX_RESET);
		foreach (hi_pool[i])
			hi_pool[i] = 54'({$urandom, $urandom});
		dir_tab = '{
			'{lpht_pkg::KIND_GET,     64'd5,    64'd77,  1, '{0, 64'd77, 0, 11'd0, 0}},
			'{lpht_pkg::KIND_POPITEM, 64'd0,    64'd0,   1, '{0, 0, 0, 11'd0, 0}},
			'{KIND_RSV6,              KEY_MAX,  KEY_MAX, 1, '{0, 0, 0, 11'd0, 0}},
			'{KIND_RSV7,              KEY_MIN,  KEY_MIN, 1, '{0, 0, 0, 11'd0, 0}},
			'{lpht_pkg::KIND_SET,     KEY_MIN,  KEY_MAX, 1, '{0, 0, 0, 11'd1, 0}},
			'{lpht_pkg::KIND_SET,     KEY_MAX,  KEY_MIN, 1, '{0, 0, 0, 11'd2, 0}},
			'{lpht_pkg::KIND_GET,     KEY_MIN,  64'd0,   1, '{1, KEY_MAX, 0, 11'd2, 0}},
			'{lpht_pkg::KIND_GET,     KEY_MAX,  64'd0,   1, '{1, KEY_MIN, 0, 11'd2, 0}},
			'{lpht_pkg::KIND_SET,     64'd1024, 64'd9,   0, '0},
			'{lpht_pkg::KIND_SET,     KEY_MIN,  64'd3,   1, '{1, 0, 0, 11'd3, 0}},
			'{lpht_pkg::KIND_SETDEF,  64'd1024, 64'd5,   1, '{1, 64'd9, 0, 11'd3, 0}},
			'{lpht_pkg::KIND_SETDEF,  64'd2048, 64'd6,   0, '0},
			'{lpht_pkg::KIND_POP,     KEY_MIN,  64'd0,   1, '{1, 64'd3, 0, 11'd3, 0}},
			'{lpht_pkg::KIND_POP,     KEY_MIN,  64'd0,   1, '{0, 0, 0, 11'd3, 0}},
			'{lpht_pkg::KIND_SETDEF,  64'd0,    64'd1,   0, '0},
			'{lpht_pkg::KIND_POPITEM, 64'd0,    64'd0,   0, '0},
			'{lpht_pkg::KIND_GET,     '1,       64'd42,  0, '0},
			'{lpht_pkg::KIND_CLEAR,   '1,       '1,      1, '{0, 0, 0, 11'd0, 0}},
			'{lpht_pkg::KIND_POPITEM, 64'd0,    64'd0,   1, '{0, 0, 0, 11'd0, 0}},
			'{lpht_pkg::KIND_SET,     '1,       '1,      1, '{0, 0, 0, 11'd1, 0}}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_request(dir_tab[i].kind, dir_tab[i].key, dir_tab[i].val,
				dir_tab[i].typed, dir_tab[i].ans);

		write_limit(11'd1);
		random_burst(40);

		write_limit(11'd1024);
		random_burst(570);

		// limit above the slot count
		write_limit(11'd2047);
		random_burst(10);

		quiet = 1'b1;
		write_limit(11'd5);
		send_request(lpht_pkg::KIND_POPITEM, '0, '0, 1'b0, '0);
		random_burst(60);

		s_tvalid <= 1'b0;
		while (answer_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d requests, %0d results, %0d refused inserts", n_req, n_res,
			n_refused);
		$display("limits 1, 1024, 2047 and 5 with a long receiver stall; %0d mismatches",
			n_err);
		if (n_err == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

FILE: filelist.f
sv/lpht_pkg.sv
sv/lpht_reduce.sv
sv/lpht_store.sv
sv/linear_probe_hash_table.sv
dv/testbench.sv
